FILE: rtl/qpr_pkg.sv
// package for the quaternion point rotation block: payload types and pipeline constants
`default_nettype none
package qpr_pkg;

    localparam int DIV_BITS = 34;                 // quotient bits, one per divider stage
    localparam int DEN_W    = 34;                 // width of 2*n
    localparam int NUM_W    = 68;                 // width of the dividend magnitude
    localparam int NST      = DIV_BITS + 6;       // total register stages

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } qpr_in_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               clipped;
    } qpr_out_t;

endpackage
`default_nettype wire

FILE: rtl/quaternion_point_rotation.sv
// top level: pipelined rotation of a Q15.16 point by a Q3.12 quaternion
`default_nettype none
// Rotates a point by a quaternion, returning the vector part of q*p*q^-1 rounded to
// the nearest Q15.16 value (ties toward plus infinity) and saturated to 32 bits, with
// clipped set when any coordinate was clamped. The quaternion need not be unit length:
// the result is computed exactly as M*p/n with n = |q|^2, so scaling q changes nothing,
// and an all-zero quaternion passes the point through unchanged. The block accepts one
// beat per cycle unless the pipeline holds; it runs through five stages of quaternion
// products, rotation matrix, matrix products, dot products and rounding offset, then
// a 34-stage restoring divider (one quotient bit per stage) and an output register.
// The whole pipeline holds while a finished result waits and result_ready is low.
module quaternion_point_rotation (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire qpr_pkg::qpr_in_t item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output qpr_pkg::qpr_out_t     result
);
    import qpr_pkg::*;

    localparam int PL = NST - 2;   // last stage that carries the point and zero flag

    // pipeline control: the whole chain moves together
    logic adv;
    logic vld_reg [NST];

    // point and zero-quaternion flag ride along every stage up to PL
    logic signed [31:0] pt_reg   [PL+1][3];
    logic               zero_reg [PL+1];

    // stage 0: quaternion products
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;

    // stage 1: rotation matrix scaled by n
    logic signed [33:0] row_reg [3][3];
    logic signed [33:0] n1_reg;

    // stage 2: matrix times point
    logic signed [65:0] prod_reg [3][3];
    logic signed [33:0] n2_reg;

    // stage 3: dot products
    logic signed [67:0] sum_reg [3];
    logic signed [33:0] n3_reg;

    // stage 4 and divider stages: remainder, dividend bits, quotient
    logic [DEN_W-1:0]    rem_reg [DIV_BITS+1][3];
    logic [DIV_BITS-1:0] lo_reg  [DIV_BITS+1][3];
    logic [DIV_BITS-1:0] qt_reg  [DIV_BITS+1][3];
    logic                neg_reg [DIV_BITS+1][3];
    logic [DEN_W-1:0]    den_reg [DIV_BITS+1];

    // output register
    qpr_out_t res_reg;

    // combinational helpers
    logic signed [33:0]  t01, t02, t10, t12, t20, t21;
    logic signed [69:0]  num    [3];
    logic signed [69:0]  mag    [3];
    logic [DEN_W-1:0]    den4;
    logic [DEN_W-1:0]    rem_next [DIV_BITS][3];
    logic [DIV_BITS-1:0] lo_next  [DIV_BITS][3];
    logic [DIV_BITS-1:0] qt_next  [DIV_BITS][3];
    logic [DEN_W:0]      trial    [DIV_BITS][3];
    logic                ge       [DIV_BITS][3];
    logic signed [34:0]  sq       [3];
    logic signed [31:0]  sat      [3];
    logic                clip     [3];
    qpr_out_t            res_next;

    assign adv          = !vld_reg[NST-1] || result_ready;
    assign item_ready   = adv;
    assign result_valid = vld_reg[NST-1];
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // off-diagonal terms before doubling
    assign t01 = 34'(xy_reg) - 34'(wz_reg);
    assign t02 = 34'(xz_reg) + 34'(wy_reg);
    assign t10 = 34'(xy_reg) + 34'(wz_reg);
    assign t12 = 34'(yz_reg) - 34'(wx_reg);
    assign t20 = 34'(xz_reg) - 34'(wy_reg);
    assign t21 = 34'(yz_reg) + 34'(wx_reg);

    // rounding: floor((2N + n) / 2n), negative dividends biased for floor
    assign den4 = {n3_reg[DEN_W-2:0], 1'b0};
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = (70'(sum_reg[i]) <<< 1) + 70'(n3_reg);
            mag[i] = num[i][69] ? (-num[i] + $signed({36'd0, den4}) - 70'sd1) : num[i];
        end
    end

    // one restoring step per divider stage
    always_comb
    begin
        for (int d = 0; d < DIV_BITS; d++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[d][i]    = {rem_reg[d][i], lo_reg[d][i][DIV_BITS-1]};
                ge[d][i]       = trial[d][i] >= {1'b0, den_reg[d]};
                rem_next[d][i] = ge[d][i] ? DEN_W'(trial[d][i] - {1'b0, den_reg[d]})
                                          : trial[d][i][DEN_W-1:0];
                lo_next[d][i]  = {lo_reg[d][i][DIV_BITS-2:0], 1'b0};
                qt_next[d][i]  = {qt_reg[d][i][DIV_BITS-2:0], ge[d][i]};
            end
        end
    end

    // sign, saturation and zero-quaternion pass-through
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq[i] = neg_reg[DIV_BITS][i] ? -$signed({1'b0, qt_reg[DIV_BITS][i]})
                                         :  $signed({1'b0, qt_reg[DIV_BITS][i]});
            if (sq[i] > 35'sd2147483647)
            begin
                sat[i]  = 32'sh7fffffff;
                clip[i] = 1'b1;
            end
            else if (sq[i] < -35'sd2147483648)
            begin
                sat[i]  = 32'sh80000000;
                clip[i] = 1'b1;
            end
            else
            begin
                sat[i]  = sq[i][31:0];
                clip[i] = 1'b0;
            end
        end
        if (zero_reg[PL])
        begin
            res_next.rot_x   = pt_reg[PL][0];
            res_next.rot_y   = pt_reg[PL][1];
            res_next.rot_z   = pt_reg[PL][2];
            res_next.clipped = 1'b0;
        end
        else
        begin
            res_next.rot_x   = sat[0];
            res_next.rot_y   = sat[1];
            res_next.rot_z   = sat[2];
            res_next.clipped = clip[0] | clip[1] | clip[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 0
            ww_reg <= item.quat_w * item.quat_w;
            xx_reg <= item.quat_x * item.quat_x;
            yy_reg <= item.quat_y * item.quat_y;
            zz_reg <= item.quat_z * item.quat_z;
            xy_reg <= item.quat_x * item.quat_y;
            wz_reg <= item.quat_w * item.quat_z;
            xz_reg <= item.quat_x * item.quat_z;
            wy_reg <= item.quat_w * item.quat_y;
            yz_reg <= item.quat_y * item.quat_z;
            wx_reg <= item.quat_w * item.quat_x;
            pt_reg[0][0] <= item.point_x;
            pt_reg[0][1] <= item.point_y;
            pt_reg[0][2] <= item.point_z;
            zero_reg[0]  <= (item.quat_w == 16'sd0) && (item.quat_x == 16'sd0) &&
                            (item.quat_y == 16'sd0) && (item.quat_z == 16'sd0);
            for (int s = 1; s <= PL; s++)
            begin
                pt_reg[s]   <= pt_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end

            // stage 1
            n1_reg        <= 34'(ww_reg) + 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg);
            row_reg[0][0] <= 34'(ww_reg) + 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg);
            row_reg[1][1] <= 34'(ww_reg) - 34'(xx_reg) + 34'(yy_reg) - 34'(zz_reg);
            row_reg[2][2] <= 34'(ww_reg) - 34'(xx_reg) - 34'(yy_reg) + 34'(zz_reg);
            row_reg[0][1] <= t01 <<< 1;
            row_reg[0][2] <= t02 <<< 1;
            row_reg[1][0] <= t10 <<< 1;
            row_reg[1][2] <= t12 <<< 1;
            row_reg[2][0] <= t20 <<< 1;
            row_reg[2][1] <= t21 <<< 1;

            // stage 2
            n2_reg <= n1_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= 66'(row_reg[i][j]) * 66'(pt_reg[1][j]);
                end
            end

            // stage 3
            n3_reg <= n2_reg;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= 68'(prod_reg[i][0]) + 68'(prod_reg[i][1]) +
                              68'(prod_reg[i][2]);
            end

            // stage 4: load the divider
            den_reg[0] <= den4;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= mag[i][NUM_W-1:DIV_BITS];
                lo_reg[0][i]  <= mag[i][DIV_BITS-1:0];
                qt_reg[0][i]  <= '0;
                neg_reg[0][i] <= num[i][69];
            end

            // divider stages
            for (int d = 0; d < DIV_BITS; d++)
            begin
                den_reg[d+1] <= den_reg[d];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[d+1][i] <= rem_next[d][i];
                    lo_reg[d+1][i]  <= lo_next[d][i];
                    qt_reg[d+1][i]  <= qt_next[d][i];
                    neg_reg[d+1][i] <= neg_reg[d][i];
                end
            end

            // output stage
            res_reg <= res_next;
        end
    end

    // a clipped beat carries at least one clamped coordinate
    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.clipped |->
            (result.rot_x == 32'sh7fffffff) || (result.rot_x == 32'sh80000000) ||
            (result.rot_y == 32'sh7fffffff) || (result.rot_y == 32'sh80000000) ||
            (result.rot_z == 32'sh7fffffff) || (result.rot_z == 32'sh80000000))
        else $error("clipped set without a saturated coordinate");

    // a nonzero quaternion reaches the divider with a nonzero divisor
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && !zero_reg[4] |-> den_reg[0] != '0)
        else $error("zero divisor for nonzero quaternion");

    // the final remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PL] && !zero_reg[PL] |->
            (rem_reg[DIV_BITS][0] < den_reg[DIV_BITS]) &&
            (rem_reg[DIV_BITS][1] < den_reg[DIV_BITS]) &&
            (rem_reg[DIV_BITS][2] < den_reg[DIV_BITS]))
        else $error("divider remainder out of range");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// testbench for the quaternion point rotation block: directed table plus random beats
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import qpr_pkg::*;

    localparam int NUM_RANDOM = 930;
    localparam int LATENCY    = 40;
    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_DIRECTED = 14;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    qpr_in_t  item;
    logic     result_valid;
    logic     result_ready;
    qpr_out_t result;

    // directed row: input, whether the expected result is typed in, and that result
    typedef struct {
        qpr_in_t  beat;
        bit       fixed;
        qpr_out_t want;
    } directed_row_t;

    directed_row_t directed_rows[NUM_DIRECTED];
    qpr_out_t      rotations_due[$];
    int            mismatch_count;
    int            idle_cycles;
    bit            stimulus_done;
    bit            hold_off;

    quaternion_point_rotation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floor division for a positive divisor
    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // one rotated coordinate: round(row . p / n), ties toward plus infinity
    function automatic longint rotated_coord(longint r0, longint r1, longint r2,
                                             longint p0, longint p1, longint p2,
                                             longint n);
        longint hi;
        longint lo;
        longint ph;
        longint d;
        longint qa;
        longint ra;
        longint r[3];
        longint p[3];
        r = '{r0, r1, r2};
        p = '{p0, p1, p2};
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++)
        begin
            ph = floor_div(p[i], 65536);
            hi += r[i] * ph;
            lo += r[i] * (p[i] - ph * 65536);
        end
        d  = 2 * n;
        qa = floor_div(2 * hi, d);
        ra = 2 * hi - qa * d;
        return qa * 65536 + floor_div(ra * 65536 + 2 * lo + n, d);
    endfunction

    // clamp to 32 bits, noting saturation
    function automatic logic signed [31:0] clamp32(longint v, ref logic clip);
        if (v > 64'sd2147483647)
        begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // exact rotation of the point by the (unnormalized) quaternion
    function automatic qpr_out_t rotate_point(qpr_in_t b);
        longint w;
        longint x;
        longint y;
        longint z;
        longint px;
        longint py;
        longint pz;
        longint ww;
        longint xx;
        longint yy;
        longint zz;
        longint n;
        logic   clip;
        qpr_out_t o;
        w  = b.quat_w;
        x  = b.quat_x;
        y  = b.quat_y;
        z  = b.quat_z;
        px = b.point_x;
        py = b.point_y;
        pz = b.point_z;
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        n  = ww + xx + yy + zz;
        clip = 1'b0;
        if (n == 0)
        begin
            // zero quaternion acts as identity
            o.rot_x = b.point_x;
            o.rot_y = b.point_y;
            o.rot_z = b.point_z;
        end
        else
        begin
            o.rot_x = clamp32(rotated_coord(ww + xx - yy - zz, 2 * (x * y - w * z),
                2 * (x * z + w * y), px, py, pz, n), clip);
            o.rot_y = clamp32(rotated_coord(2 * (x * y + w * z), ww - xx + yy - zz,
                2 * (y * z - w * x), px, py, pz, n), clip);
            o.rot_z = clamp32(rotated_coord(2 * (x * z - w * y), 2 * (y * z + w * x),
                ww - xx - yy + zz, px, py, pz, n), clip);
        end
        o.clipped = clip;
        return o;
    endfunction

    function automatic qpr_in_t make_beat(int w, int x, int y, int z, int px, int py, int pz);
        qpr_in_t b;
        b.quat_w  = w[15:0];
        b.quat_x  = x[15:0];
        b.quat_y  = y[15:0];
        b.quat_z  = z[15:0];
        b.point_x = px;
        b.point_y = py;
        b.point_z = pz;
        return b;
    endfunction

    function automatic qpr_out_t make_rot(int rx, int ry, int rz, bit clip);
        qpr_out_t o;
        o.rot_x   = rx;
        o.rot_y   = ry;
        o.rot_z   = rz;
        o.clipped = clip;
        return o;
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [15:0] random_quat_part();
        int roll;
        roll = $urandom_range(9);
        if (roll < 2)
            return (roll == 0) ? 16'h8000 : 16'h7fff;
        if (roll < 6)
            return 16'($urandom_range(8192) - 4096);   // around unit length in Q3.12
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] random_coord();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return (($urandom_range(1) == 0) ? 32'h80000000 : 32'h7fffffff);
        if (roll < 5)
            return $urandom_range(2000000) - 1000000;
        return $urandom;
    endfunction

    function automatic qpr_in_t random_beat();
        qpr_in_t b;
        b.quat_w  = random_quat_part();
        b.quat_x  = random_quat_part();
        b.quat_y  = random_quat_part();
        b.quat_z  = random_quat_part();
        // a zero quaternion now and then
        if ($urandom_range(49) == 0)
            {b.quat_w, b.quat_x, b.quat_y, b.quat_z} = '0;
        b.point_x = random_coord();
        b.point_y = random_coord();
        b.point_z = random_coord();
        return b;
    endfunction

    // the directed table: fixed answers only where they are obvious
    initial
    begin
        // identity quaternion leaves the point alone
        directed_rows[0]  = '{make_beat(4096, 0, 0, 0, 65536, -131072, 196608), 1,
                              make_rot(65536, -131072, 196608, 0)};
        // zero quaternion passes extremes through unclipped
        directed_rows[1]  = '{make_beat(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0), 1,
                              make_rot(32'h7fffffff, 32'h80000000, 0, 0)};
        // 180 degrees about z negates x and y
        directed_rows[2]  = '{make_beat(0, 0, 0, 4096, 65536, 131072, 5), 1,
                              make_rot(-65536, -131072, 5, 0)};
        // scaled identity, most negative scalar
        directed_rows[3]  = '{make_beat(-32768, 0, 0, 0, -7, 9, 32'h80000000), 1,
                              make_rot(-7, 9, 32'h80000000, 0)};
        // 180 about x with the most negative y coordinate clips
        directed_rows[4]  = '{make_beat(0, 4096, 0, 0, 1, 32'h80000000, 0), 1,
                              make_rot(1, 32'h7fffffff, 0, 1)};
        // 90 degrees about z, unnormalized
        directed_rows[5]  = '{make_beat(1, 0, 0, 1, 65536, 0, 0), 1,
                              make_rot(0, 65536, 0, 0)};
        // all parts at the extremes
        directed_rows[6]  = '{make_beat(32767, 32767, 32767, 32767,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, '0};
        directed_rows[7]  = '{make_beat(-32768, -32768, -32768, -32768,
                              32'h80000000, 32'h80000000, 32'h80000000), 0, '0};
        directed_rows[8]  = '{make_beat(-32768, 32767, -32768, 32767,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff), 0, '0};
        // 90 degrees about x, unnormalized, with the largest point
        directed_rows[9]  = '{make_beat(4096, 4096, 0, 0,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, '0};
        // near unit length
        directed_rows[10] = '{make_beat(4096, 1, 0, 0, 12345, -678, 91011), 0, '0};
        directed_rows[11] = '{make_beat(4097, 0, 3, 0, -1, 1, -1), 0, '0};
        // small quaternions and points
        directed_rows[12] = '{make_beat(1, 1, 1, 1, 1, 0, 0), 0, '0};
        directed_rows[13] = '{make_beat(3, 0, 0, 1, -3, 3, 0), 0, '0};
    end

    // offer one beat and hold it until it is taken; valid drops only before a gap
    task automatic send_beat(qpr_in_t b, bit fixed, qpr_out_t want);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= b;
        item_valid <= 1'b1;
        rotations_due.push_back(fixed ? want : rotate_point(b));
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender
    initial
    begin
        item_valid    = 1'b0;
        item          = '0;
        rst_n         = 1'b0;
        stimulus_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_beat(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);
        for (int i = 0; i < NUM_RANDOM; i++)
            send_beat(random_beat(), 1'b0, '0);
        item_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (300) @(negedge clk);
        hold_off = 1'b1;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
    end

    // receiver ready with random stalls
    initial
    begin
        int gap;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                result_ready <= 1'b0;
            else
            begin
                gap = gap_length();
                if (gap == 0)
                    result_ready <= 1'b1;
                else
                begin
                    result_ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    // result checking against the oldest outstanding rotation
    initial
    begin
        qpr_out_t want;
        mismatch_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (rotations_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: %p", result);
                end
                else
                begin
                    want = rotations_due.pop_front();
                    if (result.rot_x !== want.rot_x || result.rot_y !== want.rot_y ||
                        result.rot_z !== want.rot_z || result.clipped !== want.clipped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("exp %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
                                want.rot_x, want.rot_y, want.rot_z, want.clipped,
                                result.rot_x, result.rot_y, result.rot_z, result.clipped);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat accepted on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // end of run
    initial
    begin
        wait (stimulus_done);
        wait (rotations_due.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && rotations_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
